>>> hw/rtl/pfca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfca_pkg
// shared types and constants of the pair force collision accumulator
// ----------------------------------------------------------------------------
package pfca_pkg;

    typedef enum logic [1:0] {
        FOP_MUL = 2'd0,
        FOP_ADD = 2'd1,
        FOP_SUB = 2'd2
    } t_fop;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

    typedef struct packed {
        logic done;
    } t_fpu_rsp;

    localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN = 64'hFFF8_0000_0000_0000;

    localparam int unsigned NUM_STEPS = 17;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned ADDR_W    = 5;

    typedef enum logic [1:0] {
        REG_Q     = 2'd0,
        REG_K     = 2'd1,
        REG_ETA   = 2'd2,
        REG_RCOLL = 2'd3
    } t_reg_idx;

endpackage

>>> hw/rtl/pfca_fpu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfca_fpu
// shared multi-cycle binary64 multiply / add / subtract unit, round to nearest even
// ----------------------------------------------------------------------------
module pfca_fpu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfca_pkg::t_fpu_req  i_req,
    input  logic [63:0]         i_a,
    input  logic [63:0]         i_b,
    output pfca_pkg::t_fpu_rsp  o_rsp,
    output logic [63:0]         o_res
);
    import pfca_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_ALIGN = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_NORM  = 7'b0010000,
        ST_SHIFT = 7'b0100000,
        ST_ROUND = 7'b1000000
    } t_state;

    t_state              r_st;
    logic [1:0]          r_cnt;
    logic [52:0]         r_ma, r_mb;
    logic [10:0]         r_d;
    logic signed [13:0]  r_se, r_e1, r_sh;
    logic [106:0]        r_m, r_mx;
    logic                r_sgn, r_zsgn, r_sub, r_done;
    logic [63:0]         r_res;

    // operand unpacking
    logic        sa, sb, sbe;
    logic [10:0] ea, eb, eua, eub;
    logic [51:0] fa, fb;
    logic [52:0] ma, mb;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, b_big;

    always_comb begin
        sa     = i_a[63];
        sb     = i_b[63];
        ea     = i_a[62:52];
        eb     = i_b[62:52];
        fa     = i_a[51:0];
        fb     = i_b[51:0];
        ma     = {|ea, fa};
        mb     = {|eb, fb};
        eua    = (ea == 11'd0) ? 11'd1 : ea;
        eub    = (eb == 11'd0) ? 11'd1 : eb;
        nan_a  = (&ea) & (|fa);
        nan_b  = (&eb) & (|fb);
        inf_a  = (&ea) & ~(|fa);
        inf_b  = (&eb) & ~(|fb);
        zero_a = ~(|i_a[62:0]);
        zero_b = ~(|i_b[62:0]);
        sbe    = (i_req.op == FOP_SUB) ? ~sb : sb;
        b_big  = i_b[62:0] > i_a[62:0];
    end

    // partial product of the 27-bit halves
    logic [26:0]  pa, pb;
    logic [53:0]  pp;
    logic [6:0]   pp_sh;
    always_comb begin
        pa    = r_cnt[1] ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        pb    = r_cnt[0] ? {1'b0, r_mb[52:27]} : r_mb[26:0];
        pp    = pa * pb;
        pp_sh = 7'd27 * ({5'd0, r_cnt[1]} + {5'd0, r_cnt[0]});
    end

    // alignment of the smaller operand with sticky
    logic [106:0] wide_b, al;
    logic         al_st;
    always_comb begin
        wide_b = {1'b0, r_mb, 53'd0};
        if (r_d >= 11'd107) begin
            al    = '0;
            al_st = |r_mb;
        end else begin
            al    = wide_b >> r_d[6:0];
            al_st = |(wide_b & ~({107{1'b1}} << r_d[6:0]));
        end
    end

    // leading zero count
    logic [6:0]         lz;
    logic signed [13:0] e1;
    always_comb begin
        lz = 7'd107;
        for (int i = 0; i < 107; i++) begin
            if (r_m[i]) lz = 7'(106 - i);
        end
        e1 = r_se + 14'sd1 - $signed({7'd0, lz});
    end

    // right shift amount for the denormal / carry path
    logic [13:0]  rsh;
    logic [106:0] rsh_m;
    logic         rsh_st;
    always_comb begin
        rsh = 14'(-r_sh);
        if (rsh >= 14'd107) begin
            rsh_m  = '0;
            rsh_st = |r_m;
        end else begin
            rsh_m  = r_m >> rsh[6:0];
            rsh_st = |(r_m & ~({107{1'b1}} << rsh[6:0]));
        end
    end

    // rounding
    logic [10:0] ef;
    logic        inc;
    logic [62:0] packed_v;
    always_comb begin
        ef       = (r_e1 >= 14'sd1) ? r_e1[10:0] : 11'd0;
        inc      = r_m[52] & ((|r_m[51:0]) | r_m[53]);
        packed_v = {ef, r_m[104:53]} + {62'd0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_req.start) begin
                        if (nan_a) begin
                            r_res  <= i_a | 64'h0008_0000_0000_0000;
                            r_done <= 1'b1;
                        end else if (nan_b) begin
                            r_res  <= i_b | 64'h0008_0000_0000_0000;
                            r_done <= 1'b1;
                        end else if (i_req.op == FOP_MUL) begin
                            if ((inf_a & zero_b) | (zero_a & inf_b)) begin
                                r_res  <= DBL_QNAN;
                                r_done <= 1'b1;
                            end else if (inf_a | inf_b) begin
                                r_res  <= {sa ^ sb, 11'h7FF, 52'd0};
                                r_done <= 1'b1;
                            end else begin
                                r_ma   <= ma;
                                r_mb   <= mb;
                                r_se   <= $signed({3'd0, eua}) + $signed({3'd0, eub})
                                          - 14'sd1022;
                                r_m    <= '0;
                                r_cnt  <= 2'd0;
                                r_sgn  <= sa ^ sb;
                                r_zsgn <= sa ^ sb;
                                r_st   <= ST_MUL;
                            end
                        end else begin
                            if (inf_a & inf_b & (sa != sbe)) begin
                                r_res  <= DBL_QNAN;
                                r_done <= 1'b1;
                            end else if (inf_a) begin
                                r_res  <= i_a;
                                r_done <= 1'b1;
                            end else if (inf_b) begin
                                r_res  <= {sbe, i_b[62:0]};
                                r_done <= 1'b1;
                            end else begin
                                r_ma   <= b_big ? mb : ma;
                                r_mb   <= b_big ? ma : mb;
                                r_se   <= $signed({3'd0, b_big ? eub : eua});
                                r_d    <= b_big ? (eub - eua) : (eua - eub);
                                r_sgn  <= b_big ? sbe : sa;
                                r_sub  <= sa ^ sbe;
                                r_zsgn <= sa & sbe;
                                r_st   <= ST_ALIGN;
                            end
                        end
                    end
                end
                ST_MUL: begin
                    r_m   <= r_m + ({53'd0, pp} << pp_sh);
                    r_cnt <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) r_st <= ST_NORM;
                end
                ST_ALIGN: begin
                    r_mx <= al | {106'd0, al_st};
                    r_st <= ST_ADD;
                end
                ST_ADD: begin
                    r_m  <= r_sub ? ({1'b0, r_ma, 53'd0} - r_mx)
                                  : ({1'b0, r_ma, 53'd0} + r_mx);
                    r_st <= ST_NORM;
                end
                ST_NORM: begin
                    if (r_m == '0) begin
                        r_res  <= {r_zsgn, 63'd0};
                        r_done <= 1'b1;
                        r_st   <= ST_IDLE;
                    end else begin
                        r_e1 <= e1;
                        r_sh <= (e1 >= 14'sd1) ? ($signed({7'd0, lz}) - 14'sd1)
                                               : (r_se - 14'sd1);
                        r_st <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    if (r_sh >= 14'sd0) r_m <= r_m << r_sh[6:0];
                    else                r_m <= rsh_m | {106'd0, rsh_st};
                    r_st <= ST_ROUND;
                end
                ST_ROUND: begin
                    if ((r_e1 >= 14'sd2047) || (packed_v[62:52] == 11'h7FF)) begin
                        r_res <= {r_sgn, 11'h7FF, 52'd0};
                    end else begin
                        r_res <= {r_sgn, packed_v};
                    end
                    r_done <= 1'b1;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_res      = r_res;

endmodule

>>> hw/rtl/pair_force_collision_accumulator_core.sv
`timescale 1ns / 1ps
// work: 17 floating-point operations per pair run one at a time through one shared unit;
//   nan/inf short-cuts in the unit finish some of them early
// the input takes a new pair only after the previous pair's work is through
// a pair marked last raises its sums once its work ends, later while older sums stall
// reset (synchronous, active low) clears the sums to +0.0, the registers to 0 and
//   returns the sequencer to idle
// ----------------------------------------------------------------------------
// pair_force_collision_accumulator_core
// accumulates gravity or spring-dashpot contact force and potential over a run of pairs
// ----------------------------------------------------------------------------
module pair_force_collision_accumulator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfca_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    // pair stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sep_x, sep_y, sep_z, radial_velocity_dot, inverse_distance, partner_mass
    input  logic [383:0]                  s_axis_tdata,
    input  logic                          s_axis_tlast,   // last_pair
    // sums out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // accel_x, accel_y, accel_z, potential
    output logic [255:0]                  m_axis_tdata
);
    import pfca_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_st;
    logic [STEP_W-1:0] r_step;

    // configuration registers
    logic [63:0] r_q, r_k, r_eta, r_rcoll;

    // latched pair
    logic [63:0] r_dx, r_dy, r_dz, r_rdv, r_rinv, r_mass;
    logic        r_last;

    // intermediate values
    logic [63:0] r_rinv2, r_x, r_rv, r_kx, r_er, r_ctc, r_pot, r_grav;
    logic [63:0] r_px, r_py, r_pz;

    // running sums
    logic [63:0] r_sx, r_sy, r_sz, r_sp;

    // output register
    logic         r_ovalid;
    logic [255:0] r_odata;

    // apb side: pready tied high, write on the access phase
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (t_reg_idx'(paddr[4:3]))
            REG_Q:     prdata = r_q;
            REG_K:     prdata = r_k;
            REG_ETA:   prdata = r_eta;
            REG_RCOLL: prdata = r_rcoll;
            default:   prdata = r_q;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q     <= '0;
            r_k     <= '0;
            r_eta   <= '0;
            r_rcoll <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:3]))
                REG_Q:     r_q     <= pwdata;
                REG_K:     r_k     <= pwdata;
                REG_ETA:   r_eta   <= pwdata;
                REG_RCOLL: r_rcoll <= pwdata;
                default:   r_q     <= r_q;
            endcase
        end
    end

    // contact when x compares below zero: not nan, sign set, not a zero
    logic        x_lt0;
    logic [63:0] scalar, neg;
    always_comb begin
        x_lt0  = r_x[63] & (|r_x[62:0]) & ~((&r_x[62:52]) & (|r_x[51:0]));
        scalar = x_lt0 ? r_ctc : r_grav;
        neg    = {~scalar[63], scalar[62:0]};
    end

    // operation schedule of the sequencer, one entry per step
    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;
    logic [63:0] op_a, op_b, fpu_res;
    t_fop        op_sel;

    always_comb begin
        op_sel = FOP_MUL;
        op_a   = r_rinv;
        op_b   = r_rinv;
        case (r_step)
            5'd0:  begin op_sel = FOP_MUL; op_a = r_rinv;  op_b = r_rinv;  end // rinv^2
            5'd1:  begin op_sel = FOP_MUL; op_a = r_rcoll; op_b = r_rinv;  end // rcoll*rinv
            5'd2:  begin op_sel = FOP_SUB; op_a = DBL_ONE; op_b = r_x;     end // overlap x
            5'd3:  begin op_sel = FOP_MUL; op_a = r_rdv;   op_b = r_rinv2; end
            5'd4:  begin op_sel = FOP_MUL; op_a = r_k;     op_b = r_x;     end
            5'd5:  begin op_sel = FOP_MUL; op_a = r_eta;   op_b = r_rv;    end
            5'd6:  begin op_sel = FOP_ADD; op_a = r_q;     op_b = r_kx;    end
            5'd7:  begin op_sel = FOP_MUL; op_a = r_mass;  op_b = r_rinv;  end // potential term
            5'd8:  begin op_sel = FOP_MUL; op_a = r_rinv2; op_b = r_pot;   end // gravity scalar
            5'd9:  begin op_sel = FOP_ADD; op_a = r_ctc;   op_b = r_er;    end // contact scalar
            5'd10: begin op_sel = FOP_MUL; op_a = neg;     op_b = r_dx;    end
            5'd11: begin op_sel = FOP_MUL; op_a = neg;     op_b = r_dy;    end
            5'd12: begin op_sel = FOP_MUL; op_a = neg;     op_b = r_dz;    end
            5'd13: begin op_sel = FOP_SUB; op_a = r_sx;    op_b = r_px;    end
            5'd14: begin op_sel = FOP_SUB; op_a = r_sy;    op_b = r_py;    end
            5'd15: begin op_sel = FOP_SUB; op_a = r_sz;    op_b = r_pz;    end
            5'd16: begin op_sel = FOP_SUB; op_a = r_sp;    op_b = r_pot;   end
            default: begin op_sel = FOP_MUL; op_a = r_rinv; op_b = r_rinv; end
        endcase
        fpu_req.start = (r_st == ST_ISSUE);
        fpu_req.op    = op_sel;
    end

    pfca_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_rsp   (fpu_rsp),
        .o_res   (fpu_res)
    );

    assign s_axis_tready = (r_st == ST_IDLE);

    // write-back of the shared unit's result into the step's destination
    always_ff @(posedge i_clk) begin
        if (r_st == ST_WAIT && fpu_rsp.done) begin
            case (r_step)
                5'd0:  r_rinv2 <= fpu_res;
                5'd1:  r_x     <= fpu_res;
                5'd2:  r_x     <= fpu_res;
                5'd3:  r_rv    <= fpu_res;
                5'd4:  r_kx    <= fpu_res;
                5'd5:  r_er    <= fpu_res;
                5'd6:  r_ctc   <= fpu_res;
                5'd7:  r_pot   <= fpu_res;
                5'd8:  r_grav  <= fpu_res;
                5'd9:  r_ctc   <= fpu_res;
                5'd10: r_px    <= fpu_res;
                5'd11: r_py    <= fpu_res;
                5'd12: r_pz    <= fpu_res;
                default: r_rv  <= r_rv;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_dx   <= s_axis_tdata[63:0];
            r_dy   <= s_axis_tdata[127:64];
            r_dz   <= s_axis_tdata[191:128];
            r_rdv  <= s_axis_tdata[255:192];
            r_rinv <= s_axis_tdata[319:256];
            r_mass <= s_axis_tdata[383:320];
            r_last <= s_axis_tlast;
        end
    end

    // sequencer, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_step   <= '0;
            r_sx     <= '0;
            r_sy     <= '0;
            r_sz     <= '0;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_step <= '0;
                        r_st   <= ST_ISSUE;
                    end
                end
                ST_ISSUE: r_st <= ST_WAIT;
                ST_WAIT: begin
                    if (fpu_rsp.done) begin
                        case (r_step)
                            5'd13:   r_sx <= fpu_res;
                            5'd14:   r_sy <= fpu_res;
                            5'd15:   r_sz <= fpu_res;
                            5'd16:   r_sp <= fpu_res;
                            default: r_sp <= r_sp;
                        endcase
                        if (r_step == STEP_W'(NUM_STEPS - 1)) begin
                            r_st <= ST_FIN;
                        end else begin
                            r_step <= r_step + 1'b1;
                            r_st   <= ST_ISSUE;
                        end
                    end
                end
                ST_FIN: begin
                    if (!r_last) begin
                        r_st <= ST_IDLE;
                    end else if (!r_ovalid) begin
                        // hand the sums over and start a fresh run
                        r_odata  <= {r_sp, r_sz, r_sy, r_sx};
                        r_ovalid <= 1'b1;
                        r_sx     <= '0;
                        r_sy     <= '0;
                        r_sz     <= '0;
                        r_sp     <= '0;
                        r_st     <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

>>> hw/rtl/pfca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfca_checker
// port-level checks of the accumulator core, bound to the top level
// ----------------------------------------------------------------------------
module pfca_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [255:0] m_axis_tdata
);

    // a pair keeps the input closed at the start of its work
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened too early after a transfer");

    // a result appears only at the end of a pair's work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result raised while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind pair_force_collision_accumulator_core pfca_checker u_pfca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks pair_force_collision_accumulator_core against an in-bench binary64 predictor
// over directed special values and random runs of pairs under several settings
// ----------------------------------------------------------------------------
module testbench;
    import pfca_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 8000000;

    typedef struct {
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] pot;
    } t_sums;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [63:0]          pwdata = '0;
    logic [63:0]          prdata;
    logic                 pready;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // sep_x, sep_y, sep_z, radial_velocity_dot, inverse_distance, partner_mass
    logic [383:0]         s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;   // last_pair
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // accel_x, accel_y, accel_z, potential
    logic [255:0]         m_axis_tdata;

    // predictor copy of the registers and running sums
    real  coef_q, coef_k, coef_eta, coef_rcoll;
    real  acc_x, acc_y, acc_z, acc_pot;
    t_sums pending_sums[$];

    int unsigned err_count = 0;
    int unsigned pairs_sent = 0;
    int unsigned sums_seen = 0;
    int unsigned cycle_count = 0;
    bit          quiet_sender = 0;
    int unsigned sink_stall = 0;
    bit          sink_quiet = 0;

    pair_force_collision_accumulator_core uut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    always #1 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL pair_force_collision_accumulator_core");
            $finish;
        end
    end

    // sink back-pressure: mostly short stalls, a few long, with quiet stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!sink_quiet && $urandom_range(0, 9) < 3)
                sink_stall <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
                                                            : $urandom_range(1, 4);
        end
        if ($urandom_range(0, 499) == 0) sink_quiet <= ~sink_quiet;
    end

    function automatic bit is_nan(logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    endfunction

    // any nan matches any nan, payloads are not defined by the arithmetic
    function automatic bit same_dbl(logic [63:0] e, logic [63:0] a);
        return (e === a) || (is_nan(e) && is_nan(a));
    endfunction

    task automatic check_field(string name, logic [63:0] e, logic [63:0] a);
        if (!same_dbl(e, a)) begin
            $error("%s mismatch: expected %h actual %h", name, e, a);
            err_count++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_sums e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sums_seen++;
            if (pending_sums.size() == 0) begin
                $error("sums transfer with nothing expected: %h", m_axis_tdata);
                err_count++;
            end else begin
                e = pending_sums.pop_front();
                check_field("accel_x",   e.ax,  m_axis_tdata[63:0]);
                check_field("accel_y",   e.ay,  m_axis_tdata[127:64]);
                check_field("accel_z",   e.az,  m_axis_tdata[191:128]);
                check_field("potential", e.pot, m_axis_tdata[255:192]);
            end
        end
    end

    // binary64 force model for one pair, pushes the sums when the run closes
    task automatic accumulate_pair(logic [63:0] dx, dy, dz, rdv, rinv, mass, logic last);
        real r_inv, r_inv2, overlap, pot_term, contact, scalar, neg;
        t_sums s;
        r_inv    = $bitstoreal(rinv);
        r_inv2   = r_inv * r_inv;
        overlap  = 1.0 - coef_rcoll * r_inv;
        contact  = coef_q + coef_k * overlap;
        contact  = contact + coef_eta * ($bitstoreal(rdv) * r_inv2);
        pot_term = $bitstoreal(mass) * r_inv;
        // contact only when the overlap compares below zero, nan falls to gravity
        scalar   = (overlap < 0.0) ? contact : r_inv2 * pot_term;
        neg      = -scalar;
        acc_x    = acc_x - neg * $bitstoreal(dx);
        acc_y    = acc_y - neg * $bitstoreal(dy);
        acc_z    = acc_z - neg * $bitstoreal(dz);
        acc_pot  = acc_pot - pot_term;
        if (last) begin
            s.ax  = $realtobits(acc_x);
            s.ay  = $realtobits(acc_y);
            s.az  = $realtobits(acc_z);
            s.pot = $realtobits(acc_pot);
            pending_sums.push_back(s);
            acc_x = 0.0; acc_y = 0.0; acc_z = 0.0; acc_pot = 0.0;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_sender || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(20, 250);
    endfunction

    task automatic send_pair(logic [63:0] dx, dy, dz, rdv, rinv, mass, logic last);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {mass, rinv, rdv, dz, dy, dx};
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        accumulate_pair(dx, dy, dz, rdv, rinv, mass, last);
        pairs_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if ($urandom_range(0, 199) == 0) quiet_sender = ~quiet_sender;
    endtask

    // drain expected sums plus one full pair time for a trailing non-last pair
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(8 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_Q:     coef_q     = $bitstoreal(value);
            REG_K:     coef_k     = $bitstoreal(value);
            REG_ETA:   coef_eta   = $bitstoreal(value);
            REG_RCOLL: coef_rcoll = $bitstoreal(value);
            default:   coef_q     = coef_q;
        endcase
    endtask

    task automatic set_coefs(logic [63:0] q, k, eta, rcoll);
        wait_idle();
        write_reg(REG_Q, q);
        write_reg(REG_K, k);
        write_reg(REG_ETA, eta);
        write_reg(REG_RCOLL, rcoll);
    endtask

    function automatic logic [63:0] dbl(real v);
        return $realtobits(v);
    endfunction

    // mostly tame finite values, sometimes raw bit patterns so every bit toggles
    function automatic logic [63:0] rand_dbl(real lo, real hi);
        real f;
        if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};
        f = $itor($urandom_range(0, 1000000)) / 1000000.0;
        return $realtobits(lo + f * (hi - lo));
    endfunction

    task automatic test_reset();
        coef_q = 0.0; coef_k = 0.0; coef_eta = 0.0; coef_rcoll = 0.0;
        acc_x = 0.0; acc_y = 0.0; acc_z = 0.0; acc_pot = 0.0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        // reset coefficients: rcoll zero, so always gravity
        send_pair(dbl(1.0), dbl(-2.0), dbl(0.5), dbl(0.0), dbl(1.0), dbl(1.0), 1'b1);
        send_pair('0, '0, '0, '0, '0, '0, 1'b1);
        set_coefs(dbl(0.5), dbl(2.0), dbl(0.25), dbl(1.0));
        // overlap exactly zero takes gravity, then contact, in one run
        send_pair(dbl(1.0), dbl(1.0), dbl(1.0), dbl(3.0), dbl(1.0), dbl(2.0), 1'b0);
        send_pair(dbl(-0.5), dbl(0.25), dbl(4.0), dbl(-3.0), dbl(2.0), dbl(1.5), 1'b1);
        // infinities, nan and denormals
        send_pair(64'h7FF0_0000_0000_0000, dbl(1.0), dbl(0.0), dbl(1.0), dbl(0.5),
                  dbl(1.0), 1'b1);
        send_pair(DBL_QNAN, dbl(1.0), dbl(1.0), dbl(1.0), dbl(0.5), dbl(1.0), 1'b1);
        send_pair(64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, dbl(1.0), dbl(0.0),
                  dbl(0.75), 64'h0000_0000_0000_0003, 1'b1);
        send_pair(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF, dbl(2.0),
                  64'hFFFF_FFFF_FFFF_FFFF, dbl(4.0), 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
        send_pair(64'h8000_0000_0000_0000, dbl(1.0), dbl(1.0), dbl(1.0), dbl(3.0),
                  dbl(-1.0), 1'b1);
        // infinite radius with zero inverse distance gives a nan overlap
        set_coefs(dbl(1.0), dbl(1.0), dbl(1.0), 64'h7FF0_0000_0000_0000);
        send_pair(dbl(1.0), dbl(2.0), dbl(3.0), dbl(1.0), dbl(0.0), dbl(1.0), 1'b1);
        send_pair(dbl(1.0), dbl(2.0), dbl(3.0), dbl(1.0), dbl(0.5), dbl(1.0), 1'b1);
        // all-ones and extreme register patterns
        set_coefs(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF,
                  64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF);
        send_pair(dbl(1.0), dbl(1.0), dbl(1.0), dbl(1.0), dbl(1.0), dbl(1.0), 1'b1);
        set_coefs(64'hFFEF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FEF_FFFF_FFFF_FFFF, dbl(1.0e300));
        send_pair(dbl(1.0), dbl(-1.0), dbl(1.0), dbl(1.0e-10), dbl(2.0), dbl(1.0), 1'b1);
    endtask

    // random runs of pairs, roughly a quarter of them closing a run
    task automatic test_random_runs(int unsigned count, real rinv_hi);
        repeat (count) begin
            send_pair(rand_dbl(-10.0, 10.0), rand_dbl(-10.0, 10.0), rand_dbl(-10.0, 10.0),
                      rand_dbl(-5.0, 5.0), rand_dbl(0.01, rinv_hi), rand_dbl(0.0, 3.0),
                      $urandom_range(0, 3) == 0);
        end
        // close any open run so its sums get checked
        send_pair(dbl(1.0), dbl(1.0), dbl(1.0), dbl(0.0), dbl(0.5), dbl(1.0), 1'b1);
    endtask

    task automatic test_random_settings();
        set_coefs(dbl(0.1), dbl(5.0), dbl(0.3), dbl(0.5));
        test_random_runs(450, 4.0);
        set_coefs(dbl(-2.0), dbl(100.0), dbl(-1.5), dbl(2.0));
        test_random_runs(450, 1.5);
        set_coefs('0, '0, '0, '0);
        test_random_runs(300, 8.0);
        set_coefs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                  dbl(0.8));
        test_random_runs(250, 3.0);
        set_coefs(64'hFFEF_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, dbl(1.0e-300), dbl(1.0));
        test_random_runs(250, 2.0);
    endtask

    initial begin
        test_reset();
        test_directed();
        test_random_settings();
        wait_idle();
        $display("covered %0d pair transfers and %0d sums transfers", pairs_sent, sums_seen);
        $display("over ten register settings, gravity, contact and special values");
        if (err_count == 0) begin
            $display("PASS pair_force_collision_accumulator_core");
        end else begin
            $display("FAIL pair_force_collision_accumulator_core");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/pfca_pkg.sv
hw/rtl/pfca_fpu.sv
hw/rtl/pair_force_collision_accumulator_core.sv
hw/rtl/pfca_checker.sv
tb/testbench.sv
